// ===== rtl/core/clra_pkg.sv =====
// Package with the shared types and constants of the circular list remove-at core.
package clra_pkg;

    // Widths of the stream fields.
    localparam int POS_BITS   = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int CNT_OUT_W  = 7;

    // Action codes carried in the input tuser.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_READ,
        S_FETCH,
        S_SHIFT,
        S_POPEND,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic set_full;
        logic set_empty;
        logic push;
        logic div_init;
        logic div_step;
        logic rd_idx;
        logic take_pop;
        logic shift;
        logic pop_dec;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic div_last;
        logic more_fetch;
        logic more_shift;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/clra_ctrl.sv =====
// Controller state machine that sequences push, modulo, read and compaction steps.
module clra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  clra_pkg::t_sts  i_sts,
    output clra_pkg::t_cmd  o_cmd
);
    import clra_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_pop && !i_sts.empty) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (i_sts.more_fetch) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_POPEND;
                end
            end
            S_SHIFT: begin
                if (!i_sts.more_shift) begin
                    n_state = S_POPEND;
                end
            end
            S_POPEND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_DECODE: begin
                if (!i_sts.is_pop) begin
                    o_cmd.set_full = i_sts.full;
                    o_cmd.push     = !i_sts.full;
                end else begin
                    o_cmd.set_empty = i_sts.empty;
                    o_cmd.div_init  = !i_sts.empty;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_READ: begin
                o_cmd.rd_idx = 1'b1;
            end
            S_FETCH: begin
                o_cmd.take_pop = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            S_POPEND: begin
                o_cmd.pop_dec = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/clra_dp.sv =====
// Datapath with the entry memory, count, serial modulo unit and output register.
module clra_dp #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  clra_pkg::t_cmd                     i_cmd,
    output clra_pkg::t_sts                     o_sts,
    input  logic                               i_action,
    input  logic signed [31:0]                 i_value,
    input  logic [clra_pkg::POS_BITS-1:0]      i_position,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic signed [31:0]                 o_popped_value,
    output logic [clra_pkg::CNT_OUT_W-1:0]     o_entry_count,
    output logic                               o_one_left
);
    import clra_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    // Entry memory, kept compacted with the head at slot zero.
    logic [VALUE_BITS-1:0] r_mem [CAPACITY];

    logic                    r_action;
    logic signed [31:0]      r_value;
    logic [POS_BITS-1:0]     r_dvd;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        n_rem;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    logic [ADDR_W-1:0]       r_ptr;
    logic [VALUE_BITS-1:0]   r_rd_data;
    logic [1:0]              r_status;
    logic signed [31:0]      r_popped;
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic signed [31:0]      r_out_popped;
    logic [CNT_OUT_W-1:0]    r_out_count;
    logic                    r_out_one;

    logic [ADDR_W-1:0]       w_rd_addr;
    logic [CNT_W:0]          w_trial;
    logic [CNT_W:0]          w_div;
    logic signed [63:0]      w_ext;
    logic [63:0]             w_rd_wide;
    logic [CNT_W-1:0]        w_ptr_ext;

    // Value width conversion on the way in and out of the memory.
    assign w_ext     = 64'(r_value);
    assign w_rd_wide = 64'(r_rd_data);
    assign w_ptr_ext = CNT_W'(r_ptr);

    // One restoring step of position mod count per cycle.
    assign w_trial = {r_rem, r_dvd[POS_BITS-1]};
    assign w_div   = {1'b0, r_count};
    always_comb begin
        if (w_trial >= w_div) begin
            n_rem = CNT_W'(w_trial - w_div);
        end else begin
            n_rem = CNT_W'(w_trial);
        end
    end

    // Read address: the removed slot, then the successor of each slot to fill.
    always_comb begin
        if (i_cmd.rd_idx) begin
            w_rd_addr = r_rem[ADDR_W-1:0];
        end else if (i_cmd.take_pop) begin
            w_rd_addr = ADDR_W'(r_ptr + 1'b1);
        end else begin
            w_rd_addr = ADDR_W'(r_ptr + 2'd2);
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[ADDR_W-1:0]] <= VALUE_BITS'(w_ext);
        end else if (i_cmd.shift) begin
            r_mem[r_ptr] <= r_rd_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Control registers: entry count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the transaction in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_dvd    <= i_position;
            r_status <= ST_OK;
            r_popped <= '0;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.set_empty) begin
            r_status <= ST_EMPTY;
        end
        if (i_cmd.div_init) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_dvd     <= r_dvd << 1;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.rd_idx) begin
            r_ptr <= r_rem[ADDR_W-1:0];
        end
        if (i_cmd.take_pop) begin
            r_popped <= signed'(w_rd_wide[31:0]);
        end
        if (i_cmd.shift) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_popped <= r_popped;
            r_out_count  <= CNT_OUT_W'(r_count);
            r_out_one    <= (r_count == CNT_W'(1));
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.is_pop     = (r_action == ACT_POP);
        o_sts.full       = (r_count == CNT_W'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.div_last   = (r_div_cnt == DIV_CNT_W'(POS_BITS - 1));
        o_sts.more_fetch = ((w_ptr_ext + 1'b1) < r_count);
        o_sts.more_shift = ((w_ptr_ext + 2'd2) < r_count);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_entry_count  = r_out_count;
    assign o_one_left     = r_out_one;

endmodule

// ===== rtl/core/circular_list_remove_at_core.sv =====
// Top level of the circular list core with append and remove-at-position.
//
//  Channel  Direction  tdata (low bit up)                      tuser
//  s_axis   in         value[31:0], position[47:32]            action
//  m_axis   out        popped_value[31:0], entry_count[38:32],  status[1:0]
//                      one_left[39]
//
// A push passes through decode and done on its way to the result register.
// A pop runs the bit-serial position mod count unit, reads the removed entry,
// then moves each later entry down one slot and decrements the count.
// An empty pop or a full push goes from decode straight to done.
// Synchronous active-low reset clears the count and the result valid; the
// memory needs no clearing pass. One transaction is processed at a time; a
// new one is taken while the previous result waits in the output register.
module circular_list_remove_at_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value[31:0], position[47:32]
    input  logic        s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // popped_value[31:0], entry_count[38:32], one_left[39]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import clra_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic signed [31:0] w_popped;
    logic [CNT_OUT_W-1:0] w_count;
    logic               w_one;

    // Sequencer.
    clra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    clra_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (s_axis_tuser),
        .i_value        (signed'(s_axis_tdata[31:0])),
        .i_position     (s_axis_tdata[47:32]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_status       (m_axis_tuser),
        .o_popped_value (w_popped),
        .o_entry_count  (w_count),
        .o_one_left     (w_one)
    );

    // Pack the result fields.
    assign m_axis_tdata = {w_one, w_count, w_popped};

endmodule

// ===== rtl/core/clra_chk.sv =====
// Port-level checker for the circular list core and its bind statement.
module clra_chk #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import clra_pkg::*;

    // A result held under back-pressure keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // Only one transaction is in work: the input closes after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted during processing");

    // An empty report leaves nothing stored and returns zero.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata == 40'd0))
        else $error("empty status with non-empty result");

    // A full report shows the store at capacity with nothing popped.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
            (m_axis_tdata[38:32] == 7'(CAPACITY) && m_axis_tdata[31:0] == 32'd0))
        else $error("full status with wrong count or value");

    // The one-left flag follows the count when the count fits the field.
    a_one_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((CAPACITY >= 128) ||
            (m_axis_tdata[39] == (m_axis_tdata[38:32] == 7'd1))))
        else $error("one-left flag disagrees with count");

endmodule

bind circular_list_remove_at_core clra_chk #(.CAPACITY(CAPACITY)) u_clra_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the circular list core with append and remove-at-position.
`timescale 1ns / 100ps

module testbench;
    import clra_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_OPS   = 1300;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    // One list operation as driven on the input stream.
    typedef struct packed {
        logic        action;
        logic [31:0] value;
        logic [15:0] position;
        logic        typed;
    } t_list_op;

    // One list result as seen on the output stream.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped;
        logic [6:0]  count;
        logic        one_left;
    } t_list_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // value[31:0], position[47:32]
    logic        s_axis_tuser  = ACT_PUSH; // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // popped_value[31:0], entry_count[38:32], one_left[39]
    logic [1:0]  m_axis_tuser;          // status[1:0]

    // Pending operations, typed-in results and results still awaited.
    t_list_op     op_q[$];
    t_list_result typed_q[$];
    t_list_result pending_q[$];
    t_list_op     live_op;

    // Predicted list contents, kept compacted with the head at slot 0.
    logic [31:0]  list_mem[CAPACITY];
    int           list_len = 0;

    int           gen_len        = 0;
    int           total_ops      = 0;
    int           accepted_cnt   = 0;
    int           error_cnt      = 0;
    int           send_gap_pct;
    int           recv_stall_pct;

    circular_list_remove_at_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (32)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue one operation; a typed-in result replaces the predicted one.
    function automatic void add_op(logic act, logic [31:0] val, logic [15:0] pos, logic typed,
                                   logic [1:0] st, logic [31:0] pv, logic [6:0] cnt,
                                   logic one);
        op_q.push_back('{action: act, value: val, position: pos, typed: typed});
        if (typed) begin
            typed_q.push_back('{status: st, popped: pv, count: cnt, one_left: one});
        end
        if (act == ACT_PUSH && gen_len < CAPACITY) begin
            gen_len++;
        end else if (act == ACT_POP && gen_len > 0) begin
            gen_len--;
        end
    endfunction

    // Position mix: full range, within the current length, and the two extremes.
    function automatic logic [15:0] pick_position();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom_range(0, 65535));
            2:       return 16'($urandom_range(0, gen_len));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Apply one operation to the predicted list and return its result.
    function automatic t_list_result apply_list_op(t_list_op op);
        t_list_result res;
        int           idx;
        res = '{status: ST_OK, popped: '0, count: '0, one_left: 1'b0};
        if (op.action == ACT_PUSH) begin
            if (list_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                list_mem[list_len] = op.value;
                list_len++;
            end
        end else if (list_len == 0) begin
            res.status = ST_EMPTY;
        end else begin
            idx = int'(op.position) % list_len;
            res.popped = list_mem[idx];
            for (int i = idx; i < list_len - 1; i++) begin
                list_mem[i] = list_mem[i + 1];
            end
            list_len--;
        end
        res.count    = list_len[6:0];
        res.one_left = (list_len == 1);
        return res;
    endfunction

    // Report a single field mismatch.
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_cnt++;
        end
    endfunction

    // Idle pattern: sender rarely and receiver often, then reversed, then none.
    always_comb begin
        if (accepted_cnt * 3 < total_ops) begin
            send_gap_pct   = 9;
            recv_stall_pct = 56;
        end else if (accepted_cnt * 3 < total_ops * 2) begin
            send_gap_pct   = 56;
            recv_stall_pct = 9;
        end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
    end

    // Input side: predict on each accepted transaction, then present the next one.
    always @(posedge i_clk) begin : drive_ops
        t_list_op     nxt;
        t_list_result res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                res = apply_list_op(live_op);
                if (live_op.typed) begin
                    res = typed_q.pop_front();
                end
                pending_q.push_back(res);
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    nxt = op_q.pop_front();
                    live_op       <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.position, nxt.value};
                    s_axis_tuser  <= nxt.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each accepted transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_list_result got;
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32], m_axis_tdata[39]};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                error_cnt++;
            end else begin
                want = pending_q.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("popped_value", want.popped, got.popped);
                check_field("entry_count", 32'(want.count), 32'(got.count));
                check_field("one_left", 32'(want.one_left), 32'(got.one_left));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Run limit.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("circular_list_remove_at_core test failed");
        $finish;
    end

    // Stimulus build, reset and end of run.
    initial begin : main_seq
        int          mode;
        int          run_len;
        logic [31:0] val;

        // Directed part: empty pops, value extremes, wrap-around positions, last entry.
        add_op(ACT_POP,  32'h0,        16'h0000, 1, ST_EMPTY, 32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'hFFFF, 1, ST_EMPTY, 32'h0,        7'd0, 1'b0);
        add_op(ACT_PUSH, 32'h7FFFFFFF, 16'h0000, 1, ST_OK,    32'h0,        7'd1, 1'b1);
        add_op(ACT_POP,  32'h0,        16'hFFFF, 1, ST_OK,    32'h7FFFFFFF, 7'd0, 1'b0);
        add_op(ACT_PUSH, 32'h80000000, 16'h0000, 1, ST_OK,    32'h0,        7'd1, 1'b1);
        add_op(ACT_PUSH, 32'h00000000, 16'hFFFF, 1, ST_OK,    32'h0,        7'd2, 1'b0);
        add_op(ACT_PUSH, 32'hFFFFFFFF, 16'h0000, 1, ST_OK,    32'h0,        7'd3, 1'b0);
        add_op(ACT_PUSH, 32'h5A5A5A5A, 16'hAAAA, 1, ST_OK,    32'h0,        7'd4, 1'b0);
        add_op(ACT_PUSH, 32'hA5A5A5A5, 16'h5555, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'hFFFFFFFF, 16'hFFFF, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'hAAAA, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h5555, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h0001, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h0000, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h0000, 1, ST_EMPTY, 32'h0,        7'd0, 1'b0);
        add_op(ACT_PUSH, 32'h00000001, 16'h0000, 1, ST_OK,    32'h0,        7'd1, 1'b1);
        add_op(ACT_PUSH, 32'h00000002, 16'h0000, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h0001, 0, ST_OK,    32'h0,        7'd0, 1'b0);
        add_op(ACT_POP,  32'h0,        16'h0007, 0, ST_OK,    32'h0,        7'd0, 1'b0);

        // Random part in episodes: fill past full, drain past empty, or mixed traffic.
        total_ops = op_q.size();
        while (op_q.size() < total_ops + RANDOM_OPS) begin
            mode = $urandom_range(0, 3);
            if (mode == 0) begin
                run_len = $urandom_range(1, 3);
                while (gen_len < CAPACITY) begin
                    val = $urandom;
                    add_op(ACT_PUSH, val, pick_position(), 0, ST_OK, 32'h0, 7'd0, 1'b0);
                end
            end else if (mode == 1) begin
                run_len = $urandom_range(1, 2);
                while (gen_len > 0) begin
                    val = $urandom;
                    add_op(ACT_POP, val, pick_position(), 0, ST_OK, 32'h0, 7'd0, 1'b0);
                end
            end else begin
                run_len = $urandom_range(10, 60);
            end
            // Overflow or underflow attempts after a fill or drain, or mixed traffic.
            repeat (run_len) begin
                val = $urandom;
                if (mode == 0) begin
                    add_op(ACT_PUSH, val, pick_position(), 0, ST_OK, 32'h0, 7'd0, 1'b0);
                end else if (mode == 1) begin
                    add_op(ACT_POP, val, pick_position(), 0, ST_OK, 32'h0, 7'd0, 1'b0);
                end else begin
                    add_op(logic'($urandom_range(0, 1)), val, pick_position(), 0,
                           ST_OK, 32'h0, 7'd0, 1'b0);
                end
            end
        end
        total_ops = op_q.size();

        // Reset held at the start, then released.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every operation and every result, then for stray output.
        while (accepted_cnt < total_ops || pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("circular_list_remove_at_core test passed");
        end else begin
            $display("circular_list_remove_at_core test failed");
        end
        $finish;
    end

endmodule
